// File: hw/rtl/rht_pkg.sv
// ----------------------------------------------------------------------------
// rht_pkg: shared types and constants for the rectangle hit test table
// table size, field widths, operation codes and the stored entry layout
// ----------------------------------------------------------------------------
`default_nettype none

package rht_pkg;

  localparam int MAX_RECTS = 80;
  localparam int COUNT_W   = $clog2(MAX_RECTS + 1);
  localparam int ADDR_W    = (MAX_RECTS > 1) ? $clog2(MAX_RECTS) : 1;
  localparam int COORD_W   = 12;
  localparam int ID_W      = 8;
  localparam int OP_W      = 2;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR = 2'd0,
    OP_ADD   = 2'd1,
    OP_QUERY = 2'd2
  } op_t;

  typedef struct packed {
    logic        [COORD_W-1:0] left;
    logic        [COORD_W-1:0] top;
    logic        [COORD_W-1:0] width;
    logic        [COORD_W-1:0] height;
    logic signed [ID_W-1:0]    id;
  } rect_entry_t;

  localparam int ENTRY_W = $bits(rect_entry_t);

endpackage

`default_nettype wire

// File: hw/rtl/rectangle_hit_test_table.sv
// ----------------------------------------------------------------------------
// rectangle_hit_test_table: table of screen rectangles with point hit testing
// clear, add and query requests; a query walks the table newest to oldest
// ----------------------------------------------------------------------------
// clear, add and unused op: result strobed the cycle after the request, and
//   a new request is taken in that same cycle (one request per cycle)
// query: on an empty table the query answers without a walk; otherwise the
//   walk reads one ram entry per cycle through the single compare unit, and
//   a hit ends the walk early
// receiver cannot stall: done is high for exactly one cycle per request
// rst (synchronous) empties the table and returns to idle; ram is not cleared
`default_nettype none

module rectangle_hit_test_table (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic        [rht_pkg::OP_W-1:0]      op,
  input  wire logic        [rht_pkg::COORD_W-1:0]   pos_x,
  input  wire logic        [rht_pkg::COORD_W-1:0]   pos_y,
  input  wire logic        [rht_pkg::COORD_W-1:0]   rect_width,
  input  wire logic        [rht_pkg::COORD_W-1:0]   rect_height,
  input  wire logic signed [rht_pkg::ID_W-1:0]      region_id,
  output logic                                      done,
  output logic signed      [rht_pkg::ID_W-1:0]      hit_id,
  output logic                                      dropped
);

  import rht_pkg::*;

  typedef enum logic {
    ST_IDLE,
    ST_SCAN
  } state_t;

  state_t               state;
  logic [COUNT_W-1:0]   count;      // number of stored rectangles
  logic [ADDR_W-1:0]    scan_idx;   // next entry to read during a walk
  logic                 more;       // scan_idx still holds an unread entry
  logic                 pipe_vld;   // ram read data belongs to the walk
  logic [COORD_W-1:0]   qx;         // query point, held for the walk
  logic [COORD_W-1:0]   qy;

  logic                 accept;
  logic                 table_full;
  logic                 ram_we;
  logic                 ram_re;
  rect_entry_t          wr_entry;
  rect_entry_t          rd_entry;
  logic [ENTRY_W-1:0]   rd_bits;

  // shared compare unit: edge sums one bit wider so they never wrap
  logic [COORD_W:0]     right_edge;
  logic [COORD_W:0]     bottom_edge;
  logic                 inside_rect;

  assign busy       = (state != ST_IDLE);
  assign accept     = start && !busy;
  assign table_full = (count >= COUNT_W'(MAX_RECTS));

  // append at the fill count, only when there is room
  assign ram_we = accept && (op == OP_ADD) && !table_full;

  assign wr_entry = '{
    left:   pos_x,
    top:    pos_y,
    width:  rect_width,
    height: rect_height,
    id:     region_id
  };

  // one read issued per walk cycle while entries remain
  assign ram_re = (state == ST_SCAN) && more;

  rht_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (MAX_RECTS)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[ADDR_W-1:0]),
    .wdata (wr_entry),
    .re    (ram_re),
    .raddr (scan_idx),
    .rdata (rd_bits)
  );

  assign rd_entry = rect_entry_t'(rd_bits);

  // half-open bounds test of the query point against the entry just read
  always_comb begin
    right_edge  = {1'b0, rd_entry.left} + {1'b0, rd_entry.width};
    bottom_edge = {1'b0, rd_entry.top} + {1'b0, rd_entry.height};
    inside_rect = (qx >= rd_entry.left) && ({1'b0, qx} < right_edge) &&
                  (qy >= rd_entry.top) && ({1'b0, qy} < bottom_edge);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      count    <= '0;
      done     <= 1'b0;
      hit_id   <= '0;
      dropped  <= 1'b0;
      pipe_vld <= 1'b0;
      more     <= 1'b0;
      scan_idx <= '0;
    end else begin
      done <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (accept) begin
            hit_id  <= '0;
            dropped <= 1'b0;
            case (op)
              OP_CLEAR: begin
                count <= '0;
                done  <= 1'b1;
              end
              OP_ADD: begin
                if (table_full) begin
                  dropped <= 1'b1;
                end else begin
                  count <= count + 1'b1;
                end
                done <= 1'b1;
              end
              OP_QUERY: begin
                qx <= pos_x;
                qy <= pos_y;
                if (count == '0) begin
                  // empty table answers at once
                  done <= 1'b1;
                end else begin
                  scan_idx <= ADDR_W'(count - 1'b1);
                  more     <= 1'b1;
                  pipe_vld <= 1'b0;
                  state    <= ST_SCAN;
                end
              end
              default: begin
                // unused op code: the table does not change
                done <= 1'b1;
              end
            endcase
          end
        end
        ST_SCAN: begin
          if (pipe_vld && inside_rect) begin
            // newest containing rectangle wins
            hit_id   <= rd_entry.id;
            done     <= 1'b1;
            pipe_vld <= 1'b0;
            more     <= 1'b0;
            state    <= ST_IDLE;
          end else if (!more) begin
            // oldest entry checked, no hit
            hit_id   <= '0;
            done     <= 1'b1;
            pipe_vld <= 1'b0;
            state    <= ST_IDLE;
          end else begin
            pipe_vld <= 1'b1;
            if (scan_idx == '0) begin
              more <= 1'b0;
            end else begin
              scan_idx <= scan_idx - 1'b1;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rht_ram.sv
// ----------------------------------------------------------------------------
// rht_ram: generic simple dual-port ram
// one write port, one read port with registered read data
// ----------------------------------------------------------------------------
`default_nettype none

module rht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                           clk,
  input  wire logic                                           we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   waddr,
  input  wire logic [WIDTH-1:0]                               wdata,
  input  wire logic                                           re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0]   raddr,
  output logic      [WIDTH-1:0]                               rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/rht_checker.sv
// ----------------------------------------------------------------------------
// rht_checker: port-level checks for the rectangle hit test table
// request to result timing and result field consistency
// ----------------------------------------------------------------------------
`default_nettype none

module rht_checker (
  input wire logic                                 clk,
  input wire logic                                 rst,
  input wire logic                                 start,
  input wire logic                                 busy,
  input wire logic        [rht_pkg::OP_W-1:0]      op,
  input wire logic                                 done,
  input wire logic signed [rht_pkg::ID_W-1:0]      hit_id,
  input wire logic                                 dropped
);

  import rht_pkg::*;

  // short requests answer in the next cycle and leave the block free
  a_short_done: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op != OP_QUERY) |=> (done && !busy))
    else $error("clear/add result not strobed in the next cycle");

  // a query either starts a walk that holds the block busy or answers at once
  a_query_walk: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && op == OP_QUERY) |=> (busy || done))
    else $error("query request produced neither walk nor result");

  // end of a walk always comes with a result
  a_walk_end: assert property (@(posedge clk) disable iff (rst)
    $fell(busy) |-> done)
    else $error("walk ended without a result");

  // a drop only follows an add and carries no hit id
  a_drop_add: assert property (@(posedge clk) disable iff (rst)
    (done && dropped) |-> ($past(start) && $past(op) == OP_ADD && hit_id == '0))
    else $error("dropped flag without an add request");

endmodule

bind rectangle_hit_test_table rht_checker u_rht_checker (
  .clk     (clk),
  .rst     (rst),
  .start   (start),
  .busy    (busy),
  .op      (op),
  .done    (done),
  .hit_id  (hit_id),
  .dropped (dropped)
);

`default_nettype wire
